FILE: src/lbc_pkg.sv
// shared types and constants of the lru block cache
package lbc_pkg;

    // func field codes
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    // depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;

    // one classified command as it leaves the front
    typedef struct packed {
        logic        is_insert;
        logic [31:0] block_number;
        logic [63:0] data_word;
        logic        last_word;
    } cmd_t;

endpackage

FILE: src/lbc_front.sv
// front end: accepts input transfers, classifies them and queues the commands
module lbc_front
    import lbc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // block_number [31:0], data_word [95:32]
    input  logic        s_tuser,   // func
    input  logic        s_tlast,   // last_word
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    cmd_t                 queue_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg, count_next;
    logic                 push;
    logic                 pop;
    cmd_t                 new_cmd;

    // classify the incoming transfer
    always_comb begin
        new_cmd.is_insert    = (s_tuser == FUNC_INSERT);
        new_cmd.block_number = s_tdata[31:0];
        new_cmd.data_word    = s_tdata[95:32];
        new_cmd.last_word    = s_tlast;
    end

    assign s_tready  = (count_reg != (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

FILE: src/lbc_back.sv
// back end: tag search, recency update, block storage and result streaming
module lbc_back
    import lbc_pkg::*;
#(
    parameter int CACHE_ENTRIES = 64,
    parameter int BLOCK_BYTES   = 512,
    parameter int TAG_BITS      = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // data_word_out
    output logic        m_tuser,   // hit
    output logic        m_tlast    // last_out
);

    localparam int WPB  = BLOCK_BYTES / 8;
    localparam int EB   = $clog2(CACHE_ENTRIES);
    localparam int CNTW = $clog2(CACHE_ENTRIES + 1);
    localparam int WB   = (WPB > 1) ? $clog2(WPB) : 1;
    localparam int DAW  = $clog2(CACHE_ENTRIES * WPB);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FIND_RD  = 4'd1;
    localparam logic [3:0] S_FIND_CHK = 4'd2;
    localparam logic [3:0] S_LOOK_RD  = 4'd3;
    localparam logic [3:0] S_LOOK_CHK = 4'd4;
    localparam logic [3:0] S_AGE_RD   = 4'd5;
    localparam logic [3:0] S_AGE_WR   = 4'd6;
    localparam logic [3:0] S_SETTOP   = 4'd7;
    localparam logic [3:0] S_DATA_RD  = 4'd8;
    localparam logic [3:0] S_DATA_OUT = 4'd9;
    localparam logic [3:0] S_MISS     = 4'd10;

    // storage
    logic [TAG_BITS-1:0] tag_mem  [CACHE_ENTRIES];
    logic [EB-1:0]       rank_mem [CACHE_ENTRIES];
    logic [63:0]         data_mem [CACHE_ENTRIES * WPB];

    logic [TAG_BITS-1:0] tag_q;
    logic [EB-1:0]       rank_q;
    logic [63:0]         data_q;

    logic [3:0]      state_reg, state_next;
    logic [CNTW-1:0] idx_reg, idx_next;
    logic [CNTW-1:0] vc_reg, vc_next;
    logic [CNTW-1:0] thr_reg, thr_next;
    logic [EB-1:0]   sel_reg, sel_next;
    logic [EB-1:0]   best_rank_reg, best_rank_next;
    logic            found_reg, found_next;
    logic            claim_reg, claim_next;
    logic            ins_active_reg, ins_active_next;
    logic [EB-1:0]   ins_slot_reg, ins_slot_next;
    logic [WB-1:0]   ins_word_reg, ins_word_next;
    logic [WB-1:0]   word_reg, word_next;

    logic            out_valid_reg, out_valid_next;
    logic [63:0]     out_data_reg, out_data_next;
    logic            out_hit_reg, out_hit_next;
    logic            out_last_reg, out_last_next;
    logic            out_free;

    logic [TAG_BITS-1:0] cmd_tag;
    logic                tag_we;
    logic                rank_we;
    logic [EB-1:0]       rank_waddr;
    logic [EB-1:0]       rank_wdata;
    logic                data_we;
    logic [EB-1:0]       wr_slot;
    logic [WB-1:0]       wr_word;
    logic [DAW-1:0]      data_waddr;
    logic [DAW-1:0]      data_raddr;
    logic                match_upd;
    logic                found_now;
    logic [EB-1:0]       best_now;

    assign cmd_tag    = TAG_BITS'(cmd.block_number);
    assign out_free   = !out_valid_reg || m_tready;
    assign data_waddr = DAW'(wr_slot) * DAW'(WPB) + DAW'(wr_word);
    assign data_raddr = DAW'(sel_reg) * DAW'(WPB) + DAW'(word_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tlast  = out_last_reg;

    // tag compare during a lookup scan, keeping the most recent match
    always_comb begin
        match_upd = (tag_q == cmd_tag) && (!found_reg || rank_q < best_rank_reg);
        found_now = found_reg || match_upd;
        best_now  = match_upd ? rank_q : best_rank_reg;
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        vc_next         = vc_reg;
        thr_next        = thr_reg;
        sel_next        = sel_reg;
        best_rank_next  = best_rank_reg;
        found_next      = found_reg;
        claim_next      = claim_reg;
        ins_active_next = ins_active_reg;
        ins_slot_next   = ins_slot_reg;
        ins_word_next   = ins_word_reg;
        word_next       = word_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_hit_next    = out_hit_reg;
        out_last_next   = out_last_reg;
        cmd_ready       = 1'b0;
        tag_we          = 1'b0;
        rank_we         = 1'b0;
        rank_waddr      = idx_reg[EB-1:0];
        rank_wdata      = rank_q + 1'b1;
        data_we         = 1'b0;
        wr_slot         = ins_slot_reg;
        wr_word         = ins_word_reg;

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    idx_next = '0;
                    if (cmd.is_insert) begin
                        if (ins_active_reg) begin
                            data_we   = 1'b1;
                            cmd_ready = 1'b1;
                        end else begin
                            claim_next = 1'b1;
                            if (vc_reg < CNTW'(CACHE_ENTRIES)) begin
                                sel_next   = vc_reg[EB-1:0];
                                thr_next   = CNTW'(CACHE_ENTRIES);
                                state_next = S_AGE_RD;
                            end else begin
                                state_next = S_FIND_RD;
                            end
                        end
                    end else begin
                        claim_next = 1'b0;
                        found_next = 1'b0;
                        state_next = (vc_reg == '0) ? S_MISS : S_LOOK_RD;
                    end
                end
            end
            S_FIND_RD: begin
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK: begin
                // least recent entry carries the highest rank
                if (rank_q == EB'(CACHE_ENTRIES - 1)) begin
                    sel_next = idx_reg[EB-1:0];
                end
                if (idx_reg[EB-1:0] == EB'(CACHE_ENTRIES - 1)) begin
                    idx_next   = '0;
                    thr_next   = CNTW'(CACHE_ENTRIES - 1);
                    state_next = S_AGE_RD;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FIND_RD;
                end
            end
            S_LOOK_RD: begin
                state_next = S_LOOK_CHK;
            end
            S_LOOK_CHK: begin
                found_next     = found_now;
                best_rank_next = best_now;
                if (match_upd) begin
                    sel_next = idx_reg[EB-1:0];
                end
                if (idx_reg + 1'b1 == vc_reg) begin
                    idx_next   = '0;
                    thr_next   = CNTW'(best_now);
                    state_next = found_now ? S_AGE_RD : S_MISS;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_LOOK_RD;
                end
            end
            S_AGE_RD: begin
                state_next = (idx_reg == vc_reg) ? S_SETTOP : S_AGE_WR;
            end
            S_AGE_WR: begin
                // entries more recent than the promoted one age by one
                if (CNTW'(rank_q) < thr_reg) begin
                    rank_we = 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_AGE_RD;
            end
            S_SETTOP: begin
                rank_we    = 1'b1;
                rank_waddr = sel_reg;
                rank_wdata = '0;
                if (claim_reg) begin
                    tag_we    = 1'b1;
                    data_we   = 1'b1;
                    wr_slot   = sel_reg;
                    wr_word   = '0;
                    cmd_ready = 1'b1;
                    if (vc_reg < CNTW'(CACHE_ENTRIES)) begin
                        vc_next = vc_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end else begin
                    word_next  = '0;
                    state_next = S_DATA_RD;
                end
            end
            S_DATA_RD: begin
                state_next = S_DATA_OUT;
            end
            S_DATA_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_hit_next   = 1'b1;
                    out_data_next  = data_q;
                    out_last_next  = (word_reg == WB'(WPB - 1));
                    if (word_reg == WB'(WPB - 1)) begin
                        cmd_ready  = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        word_next  = word_reg + 1'b1;
                        state_next = S_DATA_RD;
                    end
                end
            end
            S_MISS: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_hit_next   = 1'b0;
                    out_data_next  = '0;
                    out_last_next  = 1'b1;
                    cmd_ready      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // insert run bookkeeping after each stored word
        if (data_we) begin
            ins_slot_next = wr_slot;
            if (cmd.last_word || wr_word == WB'(WPB - 1)) begin
                ins_active_next = 1'b0;
                ins_word_next   = '0;
            end else begin
                ins_active_next = 1'b1;
                ins_word_next   = wr_word + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            vc_reg         <= '0;
            ins_active_reg <= 1'b0;
            ins_slot_reg   <= '0;
            ins_word_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            vc_reg         <= vc_next;
            ins_active_reg <= ins_active_next;
            ins_slot_reg   <= ins_slot_next;
            ins_word_reg   <= ins_word_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        thr_reg       <= thr_next;
        sel_reg       <= sel_next;
        best_rank_reg <= best_rank_next;
        found_reg     <= found_next;
        claim_reg     <= claim_next;
        word_reg      <= word_next;
        out_data_reg  <= out_data_next;
        out_hit_reg   <= out_hit_next;
        out_last_reg  <= out_last_next;
    end

    // tag and rank memories, read at the scan index
    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_mem[sel_reg] <= cmd_tag;
        end
        tag_q <= tag_mem[idx_reg[EB-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (rank_we) begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
        rank_q <= rank_mem[idx_reg[EB-1:0]];
    end

    // block data memory
    always_ff @(posedge aclk) begin
        if (data_we) begin
            data_mem[data_waddr] <= cmd.data_word;
        end
        data_q <= data_mem[data_raddr];
    end

endmodule

FILE: src/lru_block_cache.sv
// top level of the lru block cache
// Fully associative cache of CACHE_ENTRIES blocks of BLOCK_BYTES bytes with
// least-recently-used replacement. An input transfer with tuser high stores
// one 64-bit word of an insert run (the first word claims a slot and takes
// the tag); tuser low looks up the tag and returns the whole block, one word
// per transfer with tuser high and tlast on the final word, or a single
// transfer with tuser low and zero data on a miss. A four-entry command queue
// decouples input from the back-end sequencer. A word of an open insert run
// is stored directly; the first word of a run ages the valid entries and
// sets the new one on top, after a victim search over all entries when the
// cache is full; a lookup searches the valid tags, then returns the result
// on a miss, or updates recency on a hit and then streams the block words.
// The tag and rank memories are read at a single scan index, so each scan
// visits one entry at a time, with a read state and a check state for each.
// No clearing pass is needed after reset.
module lru_block_cache
    import lbc_pkg::*;
#(
    parameter int CACHE_ENTRIES = 64,
    parameter int BLOCK_BYTES   = 512,
    parameter int TAG_BITS      = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // block_number [31:0], data_word [95:32]
    input  logic        s_tuser,   // func
    input  logic        s_tlast,   // last_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // data_word_out
    output logic        m_tuser,   // hit
    output logic        m_tlast    // last_out
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // accept and queue
    lbc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // execute and stream results
    lbc_back #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .BLOCK_BYTES   (BLOCK_BYTES),
        .TAG_BITS      (TAG_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // a miss result is a single transfer with zero data
    a_miss_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == '0))
        else $error("miss result not a single zero transfer");

    // the back end only retires a command that is present
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_ready |-> cmd_valid)
        else $error("command retired from empty queue");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule
